@@ rtl/kstc_pkg.sv @@
// ----------------------------------------------------------------------------
// kstc_pkg
// Shared types and constants for the keyed square transpose cipher: request
// and response payloads, operation and status codes, cell control group.
// ----------------------------------------------------------------------------
package kstc_pkg;

  // side of the square and width of a letter index
  localparam int SIDE = 5;
  localparam int LW   = 5;

  // ascii landmarks
  localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
  localparam logic [7:0] CH_UY    = 8'h59;  // 'Y'
  localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
  localparam logic [7:0] CH_LZ    = 8'h7a;  // 'z'
  localparam logic [7:0] CASE_GAP = 8'h20;

  typedef enum logic [1:0] {
    OP_KEY    = 2'd0,
    OP_FINISH = 2'd1,
    OP_ENC    = 2'd2,
    OP_DEC    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_PASS      = 2'd1,
    ST_NOT_READY = 2'd2,
    ST_REJECT    = 2'd3
  } status_t;

  typedef logic [LW-1:0] letter_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] in_char;
  } req_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic [1:0] status;
    logic       key_ready;
  } rsp_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic    shift;
    letter_t query;
  } cell_ctl_t;

endpackage

@@ rtl/keyword_square_transpose_cipher.sv @@
// ----------------------------------------------------------------------------
// keyword_square_transpose_cipher
// Keyed square transpose cipher over a chain of letter cells. Keyword letters
// shift into the chain; a finish request walks the alphabet to fill the rest.
// Keyword, pass-through and not-ready requests go straight to the output
// step; encrypt/decrypt lookups add a lookup step (cam match on acceptance,
// then transposed cell read); a finish that fills the square walks the
// alphabet (one letter per cycle, 25 steps). No new request is taken until
// the sequencer leaves its output step, where a stalled response holds it.
// Reset clears letters used, key ready, sequencer and response valid only.
// ----------------------------------------------------------------------------
module keyword_square_transpose_cipher import kstc_pkg::*; #(
  parameter int SQUARE_SIDE = SIDE
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req_data,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp_data
);

  localparam int CELLS = SQUARE_SIDE * SQUARE_SIDE;
  localparam int PW    = $clog2(CELLS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_FILL = 4'b0010,
    S_LOOK = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t           state;
  logic [CELLS-1:0] used;
  logic             ready;
  logic [PW-1:0]    walk;
  logic [PW-1:0]    pos;
  logic             lower;
  rsp_t             pend;

  logic             acc;
  logic [7:0]       ch;
  logic [7:0]       up;
  logic             key_ok;
  logic             enc_ok;
  logic             txt_ok;
  letter_t          qletter;
  logic             key_place;
  logic             fill_place;
  letter_t          din;
  cell_ctl_t        ctl;
  letter_t          cell_letter [CELLS];
  logic [CELLS-1:0] hit;
  logic [PW-1:0]    pos_hit;
  letter_t          rd_letter;
  logic [7:0]       map_char;
  logic             out_free;

  assign req_stall = (state != S_IDLE);
  assign acc       = req_valid && (state == S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  // request decode: upper-case fold and letter range checks
  assign ch      = req_data.in_char;
  assign up      = (ch >= CH_LA && ch <= CH_LZ) ? (ch - CASE_GAP) : ch;
  assign key_ok  = (ch >= CH_UA) && (ch <= CH_UY);
  assign enc_ok  = (up >= CH_UA) && (up <= CH_UY);
  assign txt_ok  = (req_data.op == OP_ENC) ? enc_ok : key_ok;
  assign qletter = letter_t'(up - CH_UA);

  // placement into the chain: keyword letter or finish walk
  assign key_place  = acc && (req_data.op == OP_KEY) && !ready && key_ok &&
                      !used[qletter[PW-1:0]];
  assign fill_place = (state == S_FILL) && !used[walk];
  assign din        = fill_place ? letter_t'(walk) : qletter;

  assign ctl.shift = key_place || fill_place;
  assign ctl.query = qletter;

  // chain of cells; cell i holds the letter placed at position CELLS-1-i
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    if (i == 0) begin : g_head
      kstc_cell u_cell (
        .clk    (clk),
        .ctl    (ctl),
        .prev   (din),
        .letter (cell_letter[i]),
        .hit    (hit[i])
      );
    end else begin : g_body
      kstc_cell u_cell (
        .clk    (clk),
        .ctl    (ctl),
        .prev   (cell_letter[i-1]),
        .letter (cell_letter[i]),
        .hit    (hit[i])
      );
    end
  end

  // encode the matching cell into its square position
  always_comb begin
    pos_hit = '0;
    for (int i = 0; i < CELLS; i++) begin
      if (hit[i]) begin
        pos_hit = pos_hit | PW'(CELLS - 1 - i);
      end
    end
  end

  // read the cell at the transposed position
  always_comb begin
    rd_letter = '0;
    for (int p = 0; p < CELLS; p++) begin
      if (pos == PW'(p)) begin
        rd_letter = cell_letter[CELLS - 1 -
                    ((p % SQUARE_SIDE) * SQUARE_SIDE + p / SQUARE_SIDE)];
      end
    end
  end

  assign map_char = (lower ? CH_LA : CH_UA) + {{(8-LW){1'b0}}, rd_letter};

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      ready     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // response valid: load from the output step, drop once taken
      if (state == S_DONE && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (key_place) begin
        used[qletter[PW-1:0]] <= 1'b1;
      end
      if (fill_place) begin
        used[walk] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (acc) begin
            if (req_data.op == OP_FINISH && !ready) begin
              state <= S_FILL;
            end else if ((req_data.op == OP_ENC || req_data.op == OP_DEC) &&
                         ready && txt_ok) begin
              state <= S_LOOK;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_FILL: begin
          if (walk == PW'(CELLS - 1)) begin
            ready <= 1'b1;
            state <= S_DONE;
          end
        end
        S_LOOK: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // response payload and lookup registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        walk  <= '0;
        pos   <= pos_hit;
        lower <= (req_data.op == OP_DEC);
        case (req_data.op)
          OP_KEY: begin
            pend.out_char  <= '0;
            pend.status    <= (ready || !key_ok) ? ST_REJECT : ST_DONE;
            pend.key_ready <= ready;
          end
          OP_FINISH: begin
            pend.out_char  <= '0;
            pend.status    <= ST_DONE;
            pend.key_ready <= 1'b1;
          end
          default: begin
            pend.out_char  <= ch;
            pend.status    <= !ready ? ST_NOT_READY : ST_PASS;
            pend.key_ready <= ready;
          end
        endcase
      end
      S_FILL: begin
        walk <= walk + 1'b1;
      end
      S_LOOK: begin
        pend.out_char  <= map_char;
        pend.status    <= ST_DONE;
        pend.key_ready <= 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          rsp_data <= pend;
        end
      end
      default: begin
        walk <= '0;
      end
    endcase
  end

endmodule

@@ rtl/kstc_cell.sv @@
// ----------------------------------------------------------------------------
// kstc_cell
// One cell of the square chain: holds one letter, takes its neighbor's letter
// on a shift and flags a match against the broadcast query letter.
// ----------------------------------------------------------------------------
module kstc_cell import kstc_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  letter_t   prev,
  output letter_t   letter,
  output logic      hit
);

  // letter storage, shifted along the chain as the square fills
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      letter <= prev;
    end
  end

  // content match for the letter lookup
  assign hit = (letter == ctl.query);

endmodule

@@ rtl/kstc_chk.sv @@
// ----------------------------------------------------------------------------
// kstc_chk
// Port-level checks for the keyed square transpose cipher, bound to the top
// level: request and response hold, sticky key ready and status consistency.
// ----------------------------------------------------------------------------
module kstc_chk import kstc_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req_data,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp_data
);

  logic seen_ready;

  // remember that a delivered response already reported a ready key
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_ready <= 1'b0;
    end else if (rsp_valid && !rsp_stall && rsp_data.key_ready) begin
      seen_ready <= 1'b1;
    end
  end

  // stalled request holds
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_stall |=> req_valid && $stable(req_data))
    else $error("stalled request changed");

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
    else $error("stalled response changed");

  // key ready never drops once reported
  a_ready_sticky: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && seen_ready |-> rsp_data.key_ready)
    else $error("key ready dropped");

  // rejected keyword bytes carry no character
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status == ST_REJECT |-> rsp_data.out_char == 8'h00)
    else $error("rejected request with nonzero character");

  // not-ready status only while the key is not ready
  a_not_ready: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status == ST_NOT_READY |-> !rsp_data.key_ready)
    else $error("not-ready status with key ready");

endmodule

bind keyword_square_transpose_cipher kstc_chk u_kstc_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req_data  (req_data),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp_data  (rsp_data)
);

@@ tb/tb_keyword_square_transpose_cipher.sv @@
// ----------------------------------------------------------------------------
// tb_keyword_square_transpose_cipher
// Self-checking bench for the keyed square transpose cipher. A directed run
// covers not-ready text, keyword extremes and rejects, duplicate letters,
// a double finish and pass-through bytes. Random text follows. Each request
// is predicted in a local model of the square when it is accepted, and every
// response is checked in order against that prediction. The sender and the
// receiver both idle at random, and the receiver holds off for long stretches.
// ----------------------------------------------------------------------------
module tb_keyword_square_transpose_cipher;
  import kstc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS      = SIDE * SIDE;
  localparam int TEXT_ITEMS = 1950;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req_data  = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp_data;

  keyword_square_transpose_cipher #(
    .SQUARE_SIDE(SIDE)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data (req_data),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_data (rsp_data)
  );

  always #6 clk = ~clk;

  // requests waiting to be sent, responses waiting to arrive
  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   error_count = 0;

  // local copy of the key square
  letter_t          square_q[CELLS];
  letter_t          position_q[CELLS];
  logic [CELLS-1:0] used_q = '0;
  int               fill_q = 0;
  logic             key_ready_q = 1'b0;

  // put a letter in the next free cell unless it is already placed
  function automatic void place_letter(letter_t l);
    if (l < CELLS && fill_q < CELLS && !used_q[l]) begin
      square_q[fill_q] = l;
      position_q[l]    = letter_t'(fill_q);
      used_q[l]        = 1'b1;
      fill_q++;
    end
  endfunction

  // letter at the transposed cell of the given letter
  function automatic letter_t transpose_letter(letter_t l);
    int row;
    int col;
    row = position_q[l] / SIDE;
    col = position_q[l] % SIDE;
    return square_q[col * SIDE + row];
  endfunction

  // expected response of one request, updates the key square
  function automatic rsp_t cipher_predict(req_t r);
    rsp_t       o;
    logic [7:0] ch;
    logic [7:0] up;
    ch         = r.in_char;
    o.out_char = 8'h00;
    o.status   = ST_DONE;
    case (op_t'(r.op))
      OP_KEY: begin
        if (key_ready_q || ch < CH_UA || ch > CH_UY) o.status = ST_REJECT;
        else place_letter(letter_t'(ch - CH_UA));
      end
      OP_FINISH: begin
        if (!key_ready_q) begin
          for (int l = 0; l < CELLS; l++) place_letter(letter_t'(l));
          key_ready_q = 1'b1;
        end
      end
      OP_ENC: begin
        up = (ch >= CH_LA && ch <= CH_LZ) ? ch - CASE_GAP : ch;
        if (!key_ready_q) begin
          o.out_char = ch;
          o.status   = ST_NOT_READY;
        end else if (up >= CH_UA && up <= CH_UY) begin
          o.out_char = CH_UA + transpose_letter(letter_t'(up - CH_UA));
        end else begin
          o.out_char = ch;
          o.status   = ST_PASS;
        end
      end
      default: begin
        if (!key_ready_q) begin
          o.out_char = ch;
          o.status   = ST_NOT_READY;
        end else if (ch >= CH_UA && ch <= CH_UY) begin
          o.out_char = CH_LA + transpose_letter(letter_t'(ch - CH_UA));
        end else begin
          o.out_char = ch;
          o.status   = ST_PASS;
        end
      end
    endcase
    o.key_ready = key_ready_q;
    return o;
  endfunction

  task automatic add_req(op_t op, logic [7:0] ch);
    req_t r;
    r.op      = op;
    r.in_char = ch;
    pending_reqs = {pending_reqs, r};
  endtask

  // text byte biased toward letters of both cases, z included
  function automatic logic [7:0] rand_text_byte();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return CH_UA + 8'($urandom_range(0, 25));
    if (pick < 7) return CH_LA + 8'($urandom_range(0, 25));
    return 8'($urandom_range(0, 255));
  endfunction

  // request driver: bursts of random length with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin : req_driver
    logic busy;
    if (rst) begin
      req_valid  <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      busy = req_valid;
      if (req_valid && !req_stall) begin
        expected_rsps = {expected_rsps, cipher_predict(req_data)};
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left == 0 && pending_reqs.size() != 0) begin
          req_data  <= pending_reqs.pop_front();
          req_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          if (gap_left != 0) gap_left--;
          req_valid <= 1'b0;
        end
      end
    end
  end

  // response stall pattern, with two long hold-offs
  int unsigned sink_cycle = 0;
  int unsigned hold_left  = 0;
  int unsigned stall_mode = 0;

  always @(posedge clk) begin : rsp_sink
    logic stall_next;
    if (rst) begin
      rsp_stall  <= 1'b0;
      sink_cycle = 0;
    end else begin
      sink_cycle++;
      if (sink_cycle == 2500 || sink_cycle == 5000) hold_left = 250;
      if (sink_cycle % 64 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_left != 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else begin
        case (stall_mode)
          0:       stall_next = 1'b0;
          1:       stall_next = ($urandom_range(0, 3) == 0);
          2:       stall_next = ($urandom_range(0, 3) != 0);
          default: stall_next = (sink_cycle % 5 < 2);
        endcase
      end
      rsp_stall <= stall_next;
    end
  end

  // response checker
  always @(posedge clk) begin : rsp_monitor
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: response with nothing pending: out_char=%h status=%0d key_ready=%b",
                 $time, rsp_data.out_char, rsp_data.status, rsp_data.key_ready);
        error_count++;
      end else begin
        want = expected_rsps.pop_front();
        if (rsp_data.out_char !== want.out_char) begin
          $display("%0t: out_char mismatch: expected %h actual %h",
                   $time, want.out_char, rsp_data.out_char);
          error_count++;
        end
        if (rsp_data.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d actual %0d",
                   $time, want.status, rsp_data.status);
          error_count++;
        end
        if (rsp_data.key_ready !== want.key_ready) begin
          $display("%0t: key_ready mismatch: expected %b actual %b",
                   $time, want.key_ready, rsp_data.key_ready);
          error_count++;
        end
      end
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    int n;
    int pick;
    // text before any key
    add_req(OP_ENC, CH_UA);
    add_req(OP_DEC, 8'hff);
    // keyword extremes, rejects and a duplicate
    add_req(OP_KEY, CH_UA);
    add_req(OP_KEY, CH_UY);
    add_req(OP_KEY, CH_UA - 8'd1);
    add_req(OP_KEY, CH_UY + 8'd1);
    add_req(OP_KEY, CH_LA);
    add_req(OP_KEY, 8'h00);
    add_req(OP_KEY, 8'hff);
    add_req(OP_KEY, CH_UA);
    add_req(OP_KEY, CH_UA + 8'd12);
    // random keyword with a few strays mixed in
    n = $urandom_range(0, 30);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 8) add_req(OP_KEY, CH_UA + 8'($urandom_range(0, 24)));
      else if (pick < 9) add_req(OP_KEY, 8'($urandom_range(0, 255)));
      else add_req($urandom_range(0, 1) ? OP_ENC : OP_DEC, rand_text_byte());
    end
    // finish twice, then keyword after ready
    add_req(OP_FINISH, 8'h00);
    add_req(OP_FINISH, 8'hff);
    add_req(OP_KEY, CH_UA + 8'd1);
    // encrypt corners
    add_req(OP_ENC, CH_LA);
    add_req(OP_ENC, CH_UA);
    add_req(OP_ENC, CH_LZ - 8'd1);
    add_req(OP_ENC, CH_UY + 8'd1);
    add_req(OP_ENC, CH_LZ);
    add_req(OP_ENC, 8'h00);
    add_req(OP_ENC, 8'hff);
    // decrypt corners
    add_req(OP_DEC, CH_UA);
    add_req(OP_DEC, CH_UY);
    add_req(OP_DEC, CH_LA);
    add_req(OP_DEC, CH_UY + 8'd1);
    add_req(OP_DEC, 8'h80);
    // random text with occasional key ops
    for (int i = 0; i < TEXT_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 46) add_req(OP_ENC, rand_text_byte());
      else if (pick < 92) add_req(OP_DEC, rand_text_byte());
      else if (pick < 96) add_req(OP_KEY, rand_text_byte());
      else add_req(OP_FINISH, 8'($urandom_range(0, 255)));
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || req_valid) @(posedge clk);
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #3000000;
    $display("%0t: run limit reached", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/kstc_pkg.sv
rtl/kstc_cell.sv
rtl/keyword_square_transpose_cipher.sv
rtl/kstc_chk.sv
tb/tb_keyword_square_transpose_cipher.sv
